@@ src/frc_pkg.sv @@
// package for the framed byte receiver: status codes, register map, config bundle
// no dependencies
`timescale 1ns / 1ps

package frc_pkg;

   localparam int unsigned ByteW     = 8;
   localparam int unsigned LenW      = 16;
   localparam int unsigned CsrDataW  = 32;
   localparam int unsigned CsrAddrW  = 3;

   localparam logic [ByteW-1:0] DefaultFrameId = 8'h41;
   localparam logic [LenW-1:0]  FrameOverhead  = 16'd4;

   typedef enum logic [1:0] {
      ST_BUSY     = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_LEN_ERR  = 2'd2,
      ST_SUM_ERR  = 2'd3
   } status_type;

   typedef enum logic {
      REG_FRAME_ID        = 1'b0,
      REG_EXPECTED_LENGTH = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [ByteW-1:0] frame_id;
      logic [LenW-1:0]  expected_length;
   } cfg_type;

endpackage

@@ src/framed_byte_receiver_checksum.sv @@
// top level of the framed byte receiver with 8-bit sum checksum
// depends on frc_pkg, frc_csr and frc_core
//
// usage:
//   req channel carries one received byte per item (req_rx_byte); rsp channel
//   returns exactly one result item per byte: the forwarded payload byte with
//   its valid flag, and a frame status (busy/idle, accepted, length mismatch,
//   checksum mismatch). the item is taken when valid is high and stall is low.
//   frame_id (address 0) and expected_length (address 4) must be set over the
//   apb-style port while the block is idle (not enforced); reads return it.
// timing:
//   one item per cycle sustained while rsp_stall is low. a taken byte lands in
//   the input register, is parsed by the state update and then lands in the
//   result register, where its result is shown.
// stall:
//   while rsp_stall holds a result, the input register keeps its byte and
//   req_stall rises once it is full; nothing is dropped or repeated.
// reset:
//   synchronous; registers return to frame id 'A' and length 4, the parser
//   goes back to hunting and both channels are emptied.
`timescale 1ns / 1ps

module framed_byte_receiver_checksum import frc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ByteW-1:0]    req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ByteW-1:0]    rsp_payload_byte,
   output logic                rsp_payload_valid,
   output logic [1:0]          rsp_frame_status,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready
);

   cfg_type    cfg;
   status_type status;

   frc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   frc_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (req_valid),
      .in_stall          (req_stall),
      .in_byte           (req_rx_byte),
      .out_valid         (rsp_valid),
      .out_stall         (rsp_stall),
      .out_payload_byte  (rsp_payload_byte),
      .out_payload_valid (rsp_payload_valid),
      .out_status        (status)
   );

   assign rsp_frame_status = status;

endmodule

@@ src/frc_csr.sv @@
// configuration registers behind the apb-style port
// depends on frc_pkg
`timescale 1ns / 1ps

module frc_csr import frc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready,
   output cfg_type             cfg
);

   logic [ByteW-1:0] frame_id_ff;
   logic [LenW-1:0]  exp_len_ff;
   logic             wr_en;
   reg_index_type    idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   // word address: byte offset bits ignored
   assign idx    = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff <= DefaultFrameId;
         exp_len_ff  <= FrameOverhead;
      end else if (wr_en) begin
         unique case (idx)
            REG_FRAME_ID:        frame_id_ff <= pwdata[ByteW-1:0];
            REG_EXPECTED_LENGTH: exp_len_ff  <= pwdata[LenW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FRAME_ID:        prdata = {{(CsrDataW-ByteW){1'b0}}, frame_id_ff};
         REG_EXPECTED_LENGTH: prdata = {{(CsrDataW-LenW){1'b0}}, exp_len_ff};
         default:             prdata = '0;
      endcase
   end

   assign cfg.frame_id        = frame_id_ff;
   assign cfg.expected_length = exp_len_ff;

endmodule

@@ src/frc_core.sv @@
// frame parser: input register, per-byte state update, result register
// depends on frc_pkg
`timescale 1ns / 1ps

module frc_core import frc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [ByteW-1:0] in_byte,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [ByteW-1:0] out_payload_byte,
   output logic             out_payload_valid,
   output status_type       out_status
);

   typedef enum logic [2:0] {
      PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CHECK
   } phase_type;

   logic             in_valid_ff;
   logic [ByteW-1:0] in_byte_ff;
   logic             out_ready;
   logic             advance;

   phase_type        phase_ff, phase_in;
   logic [ByteW-1:0] len_lo_ff, len_lo_in;
   logic [LenW-1:0]  left_ff, left_in;
   logic [ByteW-1:0] sum_ff, sum_in;
   logic [LenW-1:0]  left_dec;

   logic             res_valid_ff;
   logic [ByteW-1:0] res_byte_ff, res_byte_in;
   logic             res_pvalid_ff, res_pvalid_in;
   status_type       res_status_ff, res_status_in;

   // result register can take a new item when empty or being drained
   assign out_ready = !res_valid_ff || !out_stall;
   assign advance   = in_valid_ff && out_ready;
   assign in_stall  = in_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_stall) begin
         in_valid_ff <= in_valid;
      end
      if (!in_stall && in_valid) begin
         in_byte_ff <= in_byte;
      end
   end

   assign left_dec = left_ff - LenW'(1);

   always_comb begin
      phase_in      = phase_ff;
      len_lo_in     = len_lo_ff;
      left_in       = left_ff;
      sum_in        = sum_ff;
      res_byte_in   = '0;
      res_pvalid_in = 1'b0;
      res_status_in = ST_BUSY;
      unique case (phase_ff)
         PH_LEN_LO: begin
            len_lo_in = in_byte_ff;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if ({in_byte_ff, len_lo_ff} != cfg.expected_length ||
                cfg.expected_length < FrameOverhead) begin
               res_status_in = ST_LEN_ERR;
               phase_in      = PH_HUNT;
            end else begin
               left_in  = cfg.expected_length - FrameOverhead;
               phase_in = (cfg.expected_length == FrameOverhead) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            res_byte_in   = in_byte_ff;
            res_pvalid_in = 1'b1;
            sum_in        = sum_ff + in_byte_ff;
            left_in       = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            res_status_in = (in_byte_ff == sum_ff) ? ST_ACCEPTED : ST_SUM_ERR;
            phase_in      = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
            if (in_byte_ff == cfg.frame_id) begin
               sum_in    = '0;
               len_lo_in = '0;
               left_in   = '0;
               phase_in  = PH_LEN_LO;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         len_lo_ff    <= '0;
         left_ff      <= '0;
         sum_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff  <= phase_in;
            len_lo_ff <= len_lo_in;
            left_ff   <= left_in;
            sum_ff    <= sum_in;
         end
         if (out_ready) begin
            res_valid_ff <= in_valid_ff;
         end
      end
      if (advance) begin
         res_byte_ff   <= res_byte_in;
         res_pvalid_ff <= res_pvalid_in;
         res_status_ff <= res_status_in;
      end
   end

   assign out_valid         = res_valid_ff;
   assign out_payload_byte  = res_byte_ff;
   assign out_payload_valid = res_pvalid_ff;
   assign out_status        = res_status_ff;

   // a payload item never carries a frame status
   a_payload_no_status: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_pvalid_ff |-> res_status_ff == ST_BUSY)
      else $error("payload item carries a status");

   // payload phase always has bytes still to come
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   // the checksum byte always produces a final status
   a_check_status: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_CHECK |=>
      res_status_ff == ST_ACCEPTED || res_status_ff == ST_SUM_ERR)
      else $error("checksum byte gave no final status");

   // a non-payload item forwards a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && !res_pvalid_ff |-> res_byte_ff == '0)
      else $error("non-payload item with nonzero byte");

endmodule

@@ verif/framed_byte_receiver_checksum_tb.sv @@
// self-checking testbench for framed_byte_receiver_checksum: a queue-fed byte driver,
// a result monitor with its own frame parser as predictor, and register writes over apb
// depends on frc_pkg and the rtl under src
`timescale 1ns / 1ps

module framed_byte_receiver_checksum_tb;
   import frc_pkg::*;

   localparam int QuietLimit = 4000;
   localparam int RandomBytes = 1650;

   typedef enum logic [2:0] {
      P_HUNT,
      P_LEN_LO,
      P_LEN_HI,
      P_BODY,
      P_CHECK
   } parse_phase_type;

   typedef struct {
      logic [ByteW-1:0] pl_byte;
      logic             pl_valid;
      status_type       status;
   } rsp_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ByteW-1:0]    req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ByteW-1:0]    rsp_payload_byte;
   logic                rsp_payload_valid;
   logic [1:0]          rsp_frame_status;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CsrAddrW-1:0] paddr = '0;
   logic [CsrDataW-1:0] pwdata = '0;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   // register copy and parser state of the predictor
   cfg_type          csr_shadow;
   parse_phase_type  rx_phase;
   logic [LenW-1:0]  seen_len;
   logic [LenW-1:0]  body_left;
   logic [ByteW-1:0] body_sum;

   logic [ByteW-1:0] rx_bytes[$];
   rsp_item_type     predicted_rsp[$];

   int          errors = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   bit          sender_calm = 1'b0;
   int unsigned stall_tick = 0;
   int          stall_mode = 0;
   int          quiet_cycles = 0;

   framed_byte_receiver_checksum u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_frame_status  (rsp_frame_status),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   // expected result of one received byte, advancing the parser copy
   function automatic rsp_item_type parse_rx_byte(logic [ByteW-1:0] b);
      rsp_item_type r;
      r.pl_byte  = '0;
      r.pl_valid = 1'b0;
      r.status   = ST_BUSY;
      case (rx_phase)
         P_LEN_LO: begin
            seen_len = {8'h00, b};
            rx_phase = P_LEN_HI;
         end
         P_LEN_HI: begin
            seen_len = {b, seen_len[7:0]};
            if (seen_len != csr_shadow.expected_length ||
                csr_shadow.expected_length < FrameOverhead) begin
               r.status = ST_LEN_ERR;
               rx_phase = P_HUNT;
            end else begin
               body_left = csr_shadow.expected_length - FrameOverhead;
               rx_phase  = (body_left == 0) ? P_CHECK : P_BODY;
            end
         end
         P_BODY: begin
            r.pl_byte  = b;
            r.pl_valid = 1'b1;
            body_sum   = body_sum + b;
            if (body_left > 0) body_left = body_left - 1'b1;
            if (body_left == 0) rx_phase = P_CHECK;
         end
         P_CHECK: begin
            r.status = (b == body_sum) ? ST_ACCEPTED : ST_SUM_ERR;
            rx_phase = P_HUNT;
         end
         default: begin
            rx_phase = P_HUNT;
            if (b == csr_shadow.frame_id) begin
               body_sum  = '0;
               seen_len  = '0;
               body_left = '0;
               rx_phase  = P_LEN_LO;
            end
         end
      endcase
      return r;
   endfunction

   // header, then body and checksum unless body_len is negative; returns bytes queued
   function automatic int add_frame(logic [ByteW-1:0] id, logic [LenW-1:0] len_field,
                                    int body_len, bit bad_sum);
      logic [ByteW-1:0] sum = '0;
      logic [ByteW-1:0] v;
      rx_bytes.push_back(id);
      rx_bytes.push_back(len_field[7:0]);
      rx_bytes.push_back(len_field[15:8]);
      if (body_len < 0) return 3;
      for (int i = 0; i < body_len; i++) begin
         v = 8'($urandom);
         sum = sum + v;
         rx_bytes.push_back(v);
      end
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      rx_bytes.push_back(sum);
      return body_len + 4;
   endfunction

   function automatic void add_noise(int n, logic [ByteW-1:0] id);
      logic [ByteW-1:0] v;
      for (int i = 0; i < n; i++) begin
         v = 8'($urandom);
         if (v == id) v = ~v;
         rx_bytes.push_back(v);
      end
   endfunction

   task automatic write_csr(reg_index_type idx, logic [CsrDataW-1:0] value);
      logic [CsrDataW-1:0] want;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrW'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_FRAME_ID) csr_shadow.frame_id = value[ByteW-1:0];
      else csr_shadow.expected_length = value[LenW-1:0];
      want = (idx == REG_FRAME_ID) ? CsrDataW'(csr_shadow.frame_id)
                                   : CsrDataW'(csr_shadow.expected_length);
      // read it back
      @(posedge clock);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) begin
         $error("prdata[%s]: expected %0h, got %0h", idx.name(), want, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // sender holds off until every byte is through and every result is back
   task automatic drain();
      @(negedge clock);
      while (rx_bytes.size() != 0 || req_valid || predicted_rsp.size() != 0)
         @(negedge clock);
   endtask

   // byte driver: bursts of random length with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predicted_rsp.push_back(parse_rx_byte(req_rx_byte));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_bytes.size() > 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = sender_calm ? 0 : $urandom_range(0, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $error("result item with nothing expected");
               errors++;
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_payload_byte !== want.pl_byte) begin
                  $error("payload_byte: expected %0h, got %0h", want.pl_byte, rsp_payload_byte);
                  errors++;
               end
               if (rsp_payload_valid !== want.pl_valid) begin
                  $error("payload_valid: expected %0b, got %0b",
                         want.pl_valid, rsp_payload_valid);
                  errors++;
               end
               if (rsp_frame_status !== want.status) begin
                  $error("frame_status: expected %0d, got %0d", want.status, rsp_frame_status);
                  errors++;
               end
            end
         end
         stall_tick++;
         if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((stall_tick % 8) >= 5);
         endcase
      end
   end

   // watchdog on cycles with no item taken on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("** framed_byte_receiver_checksum: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int frame_bytes;
      int target;
      int n;
      int pick;
      int body;
      logic [ByteW-1:0] id;
      logic [LenW-1:0]  len;

      csr_shadow.frame_id        = DefaultFrameId;
      csr_shadow.expected_length = FrameOverhead;
      rx_phase  = P_HUNT;
      seen_len  = '0;
      body_left = '0;
      body_sum  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: id 'A', no payload
      rx_bytes = {8'h00, 8'hFF,
                  8'h41, 8'h04, 8'h00, 8'h00,
                  8'h41, 8'h04, 8'h00, 8'h01,
                  8'h41, 8'h05, 8'h00,
                  8'h41, 8'h04, 8'h01};
      drain();

      // length below the overhead can never match
      write_csr(REG_EXPECTED_LENGTH, 32'd3);
      rx_bytes = {8'h41, 8'h03, 8'h00};
      drain();

      // length change mid-frame keeps the payload count already taken
      write_csr(REG_EXPECTED_LENGTH, 32'd8);
      rx_bytes = {8'h41, 8'h08, 8'h00, 8'hAA};
      drain();
      write_csr(REG_EXPECTED_LENGTH, 32'd4);
      rx_bytes = {8'h55, 8'h80, 8'h7F, 8'hFE};
      drain();

      // extreme register values
      write_csr(REG_FRAME_ID, 32'd0);
      write_csr(REG_EXPECTED_LENGTH, 32'hFFFF);
      rx_bytes = {8'h00, 8'hFF, 8'h7F};
      drain();

      frame_bytes = 0;
      while (frame_bytes < RandomBytes) begin
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 3);
            id = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            write_csr(REG_FRAME_ID, CsrDataW'(id));
         end
         pick = $urandom_range(0, 7);
         len = (pick == 0) ? 16'd4 : (pick == 1) ? LenW'($urandom_range(100, 400))
                                                 : LenW'($urandom_range(5, 24));
         write_csr(REG_EXPECTED_LENGTH, CsrDataW'(len));
         id   = csr_shadow.frame_id;
         body = int'(len) - 4;
         sender_calm = ($urandom_range(0, 3) == 0);
         target = (pick == 1) ? 2 * int'(len) : $urandom_range(60, 200);
         n = 0;
         while (n < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
               n += add_frame(id, len, body, 1'b0);
            end else if (pick < 15) begin
               n += add_frame(id, len, body, 1'b1);
            end else if (pick < 17) begin
               n += add_frame(id, len ^ (16'h1 << $urandom_range(0, 15)), -1, 1'b0);
            end else if (pick < 18) begin
               // stray id: the next frame's id is taken as a length byte
               rx_bytes.push_back(id);
               n += 1;
            end else begin
               add_noise($urandom_range(1, 6), id);
            end
         end
         // sometimes leave a frame open across the next register write
         if ($urandom_range(0, 3) == 0 && body > 0) begin
            n += add_frame(id, len, -1, 1'b0);
            add_noise($urandom_range(0, (body < 8) ? body - 1 : 8), id);
         end
         frame_bytes += n;
         drain();
      end

      repeat (4) @(posedge clock);
      if (predicted_rsp.size() != 0) begin
         $error("%0d result items never arrived", predicted_rsp.size());
         errors++;
      end
      if (errors == 0) begin
         $display("** framed_byte_receiver_checksum: PASSED **");
      end else begin
         $display("** framed_byte_receiver_checksum: FAILED **");
      end
      $finish;
   end

endmodule
